FILE: sv/rsp_pkg.sv
`default_nettype none
package rsp_pkg;

  localparam int unsigned PHASE_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENTIAL_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_RED        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_GREEN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_BLUE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_GREEN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_BLUE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_END    = 3'd6;

  localparam logic [PHASE_W-1:0] PHASE_RESTART     = 16'hFFFF;
  localparam logic [PHASE_W-1:0] SEQUENCE_END_RST  = 16'd99;

  // bit positions in the led level vector
  localparam int unsigned LED_RED   = 0;
  localparam int unsigned LED_GREEN = 1;
  localparam int unsigned LED_BLUE  = 2;

  typedef logic [2:0] led_levels_t;

  typedef struct packed {
    logic               sequential_mode;
    logic [PHASE_W-1:0] duty_red;
    logic [PHASE_W-1:0] duty_green;
    logic [PHASE_W-1:0] duty_blue;
    logic [PHASE_W-1:0] start_green;
    logic [PHASE_W-1:0] start_blue;
    logic [PHASE_W-1:0] sequence_end;
  } rsp_cfg_t;

endpackage
`default_nettype wire

FILE: sv/rsp_cfg_regs.sv
`default_nettype none
module rsp_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [rsp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [rsp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output rsp_pkg::rsp_cfg_t                     cfg_o
);
  import rsp_pkg::*;

  rsp_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SEQUENTIAL_MODE: cfg_d.sequential_mode = cfg_data_i[0];
        REG_DUTY_RED:        cfg_d.duty_red        = cfg_data_i;
        REG_DUTY_GREEN:      cfg_d.duty_green      = cfg_data_i;
        REG_DUTY_BLUE:       cfg_d.duty_blue       = cfg_data_i;
        REG_START_GREEN:     cfg_d.start_green     = cfg_data_i;
        REG_START_BLUE:      cfg_d.start_blue      = cfg_data_i;
        REG_SEQUENCE_END:    cfg_d.sequence_end    = cfg_data_i;
        default:             cfg_d = cfg_q; // unknown index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sequential_mode <= 1'b0;
      cfg_q.duty_red        <= '0;
      cfg_q.duty_green      <= '0;
      cfg_q.duty_blue       <= '0;
      cfg_q.start_green     <= '0;
      cfg_q.start_blue      <= '0;
      cfg_q.sequence_end    <= SEQUENCE_END_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: sv/rsp_step.sv
`default_nettype none
module rsp_step #(
  parameter int unsigned PARALLEL_PERIOD_LAST = 99
) (
  input  wire rsp_pkg::rsp_cfg_t             cfg_i,
  input  wire logic                          tick_i,
  input  wire logic [rsp_pkg::PHASE_W-1:0]   phase_i,
  input  wire rsp_pkg::led_levels_t          led_i,
  output logic [rsp_pkg::PHASE_W-1:0]        phase_o,
  output rsp_pkg::led_levels_t               led_o
);
  import rsp_pkg::*;

  localparam logic [PHASE_W-1:0] ParLast = PHASE_W'(PARALLEL_PERIOD_LAST);

  logic [PHASE_W-1:0] p;
  logic [PHASE_W:0]   green_off, blue_off;
  logic [PHASE_W-1:0] last;
  led_levels_t        lv;

  always_comb begin
    p         = phase_i + 16'd1;
    // sums kept at 17 bits so an overflowing off edge never matches
    green_off = {1'b0, cfg_i.start_green} + {1'b0, cfg_i.duty_green};
    blue_off  = {1'b0, cfg_i.start_blue} + {1'b0, cfg_i.duty_blue};
    last      = cfg_i.sequential_mode ? cfg_i.sequence_end : ParLast;
    lv        = led_i;
    if (cfg_i.sequential_mode) begin
      if (p == '0 && cfg_i.duty_red != '0)               lv[LED_RED]   = 1'b1;
      if (p == cfg_i.duty_red)                           lv[LED_RED]   = 1'b0;
      if (p == cfg_i.start_green && cfg_i.duty_green != '0) lv[LED_GREEN] = 1'b1;
      if ({1'b0, p} == green_off)                        lv[LED_GREEN] = 1'b0;
      if (p == cfg_i.start_blue && cfg_i.duty_blue != '0)   lv[LED_BLUE]  = 1'b1;
      if ({1'b0, p} == blue_off)                         lv[LED_BLUE]  = 1'b0;
    end else begin
      if (p == '0) begin
        if (cfg_i.duty_red != '0)   lv[LED_RED]   = 1'b1;
        if (cfg_i.duty_green != '0) lv[LED_GREEN] = 1'b1;
        if (cfg_i.duty_blue != '0)  lv[LED_BLUE]  = 1'b1;
      end
      if (p == cfg_i.duty_red)   lv[LED_RED]   = 1'b0;
      if (p == cfg_i.duty_green) lv[LED_GREEN] = 1'b0;
      if (p == cfg_i.duty_blue)  lv[LED_BLUE]  = 1'b0;
    end

    if (tick_i) begin
      phase_o = (p >= last) ? PHASE_RESTART : p;
      led_o   = lv;
    end else begin
      phase_o = phase_i;
      led_o   = led_i;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rgb_soft_pwm_sequencer.sv
// channel  | direction | handshake            | payload
// in       | sink      | in_valid_i/in_stall_o  | tick_i
// out      | source    | out_valid_o/out_stall_i| red_on_o green_on_o blue_on_o phase_o
// cfg      | sink      | cfg_we_i (no wait)     | cfg_idx_i cfg_data_i
//
// one tick transfer per clock sustained while the output is not stalled; a result
// is offered once its input transfer has loaded the input register and the
// item has then moved on into the result register
// the phase counter and led levels are updated as an item moves from the
// input register into the result register, so each item sees the state
// left by the one before it
// reset: phase 0xffff, all leds off, sequence_end 99, other config registers 0
// a stall on the output holds the result register and backs up into the
// input register, which then stalls the input channel
`default_nettype none
module rgb_soft_pwm_sequencer #(
  parameter int unsigned PARALLEL_PERIOD_LAST = 99
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            tick_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 red_on_o,
  output logic                                 green_on_o,
  output logic                                 blue_on_o,
  output logic [rsp_pkg::PHASE_W-1:0]          phase_o,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [rsp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [rsp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import rsp_pkg::*;

  rsp_cfg_t cfg;

  // input register
  logic in_valid_q, in_valid_d;
  logic tick_q, tick_d;

  // block state
  logic [PHASE_W-1:0] phase_q, phase_d;
  led_levels_t        led_q, led_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [PHASE_W-1:0] out_phase_q, out_phase_d;
  led_levels_t        out_led_q, out_led_d;

  logic out_free;   // result register can load this cycle
  logic advance;    // item moves from input register to result register
  logic in_xfer;

  logic [PHASE_W-1:0] step_phase;
  led_levels_t        step_led;

  rsp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rsp_step #(
    .PARALLEL_PERIOD_LAST (PARALLEL_PERIOD_LAST)
  ) u_step (
    .cfg_i   (cfg),
    .tick_i  (tick_q),
    .phase_i (phase_q),
    .led_i   (led_q),
    .phase_o (step_phase),
    .led_o   (step_led)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  // input register frees up whenever its item moves on
  assign in_stall_o = in_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d  = in_valid_q;
    tick_d      = tick_q;
    phase_d     = phase_q;
    led_d       = led_q;
    out_valid_d = out_valid_q;
    out_phase_d = out_phase_q;
    out_led_d   = out_led_q;

    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (in_xfer) begin
      in_valid_d = 1'b1;
      tick_d     = tick_i;
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      // state and result both take the stepped values
      phase_d     = step_phase;
      led_d       = step_led;
      out_valid_d = 1'b1;
      out_phase_d = step_phase;
      out_led_d   = step_led;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PHASE_RESTART;
      led_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      phase_q     <= phase_d;
      led_q       <= led_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    tick_q      <= tick_d;
    out_phase_q <= out_phase_d;
    out_led_q   <= out_led_d;
  end

  assign out_valid_o = out_valid_q;
  assign red_on_o    = out_led_q[LED_RED];
  assign green_on_o  = out_led_q[LED_GREEN];
  assign blue_on_o   = out_led_q[LED_BLUE];
  assign phase_o     = out_phase_q;

endmodule
`default_nettype wire

FILE: sv/rsp_checker.sv
`default_nettype none
module rsp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        red_on_o,
  input wire logic        green_on_o,
  input wire logic        blue_on_o,
  input wire logic [15:0] phase_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(phase_o) && $stable(red_on_o)
      && $stable(green_on_o) && $stable(blue_on_o))
    else $error("stalled result changed");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with the output free");

  // an input transfer always yields a result when the output is then unstalled
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after input transfer");

endmodule

bind rgb_soft_pwm_sequencer rsp_checker u_rsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .red_on_o    (red_on_o),
  .green_on_o  (green_on_o),
  .blue_on_o   (blue_on_o),
  .phase_o     (phase_o)
);
`default_nettype wire
